// ===== sv/tts_pkg.sv =====
// Shared types and constants for the tensor transpose scatter block.
// No dependencies; every other file imports this package.
package tts_pkg;

    localparam int NUM_SIZES  = 6;
    localparam int DIM_W      = 3;
    localparam int SIZE_W     = 13;
    localparam int COORD_W    = 12;
    localparam int PE_W       = 3;
    localparam int PERM_W     = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int VALUE_W    = 64;
    localparam int DEST_W     = 48;

    localparam logic [SIZE_W-1:0] SIZE_CAP   = 13'd4096;
    localparam logic [PERM_W-1:0] PERM_RESET = 18'd181896;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIM_COUNT = 3'd0,
        REG_SIZE_D0   = 3'd1,
        REG_SIZE_D1   = 3'd2,
        REG_SIZE_D2   = 3'd3,
        REG_SIZE_D3   = 3'd4,
        REG_SIZE_D4   = 3'd5,
        REG_SIZE_D5   = 3'd6,
        REG_PERM      = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        SET_IDLE,
        SET_POS,
        SET_STRIDE,
        SET_REW,
        SET_CNT,
        SET_FIN
    } setup_state_t;

    typedef struct packed {
        logic busy;
        logic restart;
        logic size_overflow;
    } setup_stat_t;

    typedef struct packed {
        logic [DEST_W-1:0]  dest_offset;
        logic [VALUE_W-1:0] value_out;
        logic               last_element;
        logic               size_overflow;
    } result_t;

    // Zero reads as one, anything above the cap saturates.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] r;
        r = s;
        if (s == '0) begin
            r = SIZE_W'(1);
        end
        else if (s > SIZE_CAP) begin
            r = SIZE_CAP;
        end
        return r;
    endfunction

endpackage

// ===== sv/tts_if.sv =====
// Stream interfaces for element beats in and result beats out.
// Depends on tts_pkg for field widths.
interface tts_elem_if import tts_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

interface tts_result_if import tts_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DEST_W-1:0]  dest_offset;
    logic [VALUE_W-1:0] value_out;
    logic               last_element;
    logic               size_overflow;

    modport source (output valid, output dest_offset, output value_out,
                    output last_element, output size_overflow, input ready);
    modport sink   (input valid, input dest_offset, input value_out,
                    input last_element, input size_overflow, output ready);
endinterface

// ===== sv/tts_cfg.sv =====
// Configuration registers and the setup sequencer that derives per-dimension
// carry steps and the overflow flag with a shared shift-add multiplier.
// Depends on tts_pkg.
module tts_cfg
    import tts_pkg::*;
#(
    parameter int MAX_DIMS    = 6,
    parameter int OFFSET_BITS = 48
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic [DIM_W-1:0]       dims,
    output logic [COORD_W-1:0]     coord_max [MAX_DIMS],
    output logic [OFFSET_BITS-1:0] carry_step [MAX_DIMS],
    output setup_stat_t            stat
);

    localparam int IDX_W  = $clog2(MAX_DIMS);
    localparam int CNT_W  = COORD_W * MAX_DIMS + 1;
    localparam int MUL_W  = (OFFSET_BITS + 1 > CNT_W) ? OFFSET_BITS + 1 : CNT_W;
    localparam int STEP_W = $clog2(SIZE_W + 1);
    localparam logic [STEP_W-1:0] LAST_STEP   = STEP_W'(SIZE_W);
    localparam logic [IDX_W-1:0]  LAST_IDX    = IDX_W'(MAX_DIMS - 1);
    localparam logic [MUL_W-1:0]  OFFSET_SPAN = MUL_W'(1) << OFFSET_BITS;

    logic [DIM_W-1:0]       dim_count_reg;
    logic [SIZE_W-1:0]      size_reg [NUM_SIZES];
    logic [PERM_W-1:0]      perm_reg;

    logic [SIZE_W-1:0]      esz_all [NUM_SIZES];
    logic [SIZE_W-1:0]      esz [MAX_DIMS];
    logic [PE_W-1:0]        pe [MAX_DIMS];

    setup_state_t           state_reg, state_next;
    logic [IDX_W-1:0]       k_reg, k_next, k_prev;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [MUL_W-1:0]       mcand_reg, mcand_next;
    logic [SIZE_W-1:0]      mplier_reg, mplier_next;
    logic [MUL_W-1:0]       prod_reg, prod_next;
    logic [MUL_W-1:0]       mul_sum;
    logic                   mul_done;
    logic [MUL_W-1:0]       op_a;
    logic [SIZE_W-1:0]      op_b;
    logic [SIZE_W-1:0]      pos_factor;

    logic [OFFSET_BITS-1:0] pos_reg [MAX_DIMS];
    logic [OFFSET_BITS-1:0] pos_next [MAX_DIMS];
    logic [OFFSET_BITS-1:0] stride_reg [MAX_DIMS];
    logic [OFFSET_BITS-1:0] stride_next [MAX_DIMS];
    logic [OFFSET_BITS-1:0] delta_reg [MAX_DIMS];
    logic [OFFSET_BITS-1:0] delta_next [MAX_DIMS];
    logic [OFFSET_BITS-1:0] rew_acc_reg, rew_acc_next;
    logic [MUL_W-1:0]       cnt_reg, cnt_next;
    logic                   ovf_reg, ovf_next;
    logic                   hit;

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            dim_count_reg <= DIM_W'(1);
            for (int i = 0; i < NUM_SIZES; i++) begin
                size_reg[i] <= SIZE_W'(1);
            end
            perm_reg <= PERM_RESET;
        end
        else if (cfg_we) begin
            case (cfg_index) inside
                REG_DIM_COUNT: dim_count_reg <= cfg_data[DIM_W-1:0];
                [REG_SIZE_D0:REG_SIZE_D5]:
                    size_reg[CFG_IDX_W'(cfg_index - REG_SIZE_D0)] <= cfg_data[SIZE_W-1:0];
                REG_PERM: perm_reg <= cfg_data[PERM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_SIZES; i++) begin
            esz_all[i] = eff_size(size_reg[i]);
        end
        for (int d = 0; d < MAX_DIMS; d++) begin
            esz[d]       = esz_all[d];
            coord_max[d] = COORD_W'(esz_all[d] - SIZE_W'(1));
            pe[d]        = perm_reg[PE_W*d +: PE_W];
        end
        if (dim_count_reg == '0) begin
            dims = DIM_W'(1);
        end
        else if (int'(dim_count_reg) > MAX_DIMS) begin
            dims = DIM_W'(MAX_DIMS);
        end
        else begin
            dims = dim_count_reg;
        end
    end

    assign k_prev  = k_reg - IDX_W'(1);
    assign mul_sum = prod_reg + (mplier_reg[0] ? mcand_reg : '0);

    // A size factor counts only when its position and its source dimension are in use.
    assign pos_factor = (int'(k_reg) < int'(dims) && int'(pe[k_prev]) < int'(dims)) ?
                        esz_all[pe[k_prev]] : SIZE_W'(1);

    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        step_next    = step_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        prod_next    = prod_reg;
        pos_next     = pos_reg;
        stride_next  = stride_reg;
        delta_next   = delta_reg;
        rew_acc_next = rew_acc_reg;
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        mul_done     = 1'b0;
        op_a         = '0;
        op_b         = '0;
        hit          = 1'b0;

        case (state_reg)
            SET_POS: begin
                op_a = MUL_W'(pos_reg[k_prev]);
                op_b = pos_factor;
            end
            SET_REW: begin
                op_a = MUL_W'(stride_reg[k_reg]);
                op_b = {1'b0, coord_max[k_reg]};
            end
            SET_CNT: begin
                op_a = cnt_reg;
                op_b = esz[k_reg];
            end
            default: ;
        endcase

        // Shift-add multiply: a load step takes the operands, then one multiplier bit per cycle
        if (state_reg inside {SET_POS, SET_REW, SET_CNT}) begin
            if (step_reg == '0) begin
                mcand_next  = op_a;
                mplier_next = op_b;
                prod_next   = '0;
                step_next   = STEP_W'(1);
            end
            else begin
                prod_next   = mul_sum;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                step_next   = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP) begin
                    mul_done  = 1'b1;
                    step_next = '0;
                end
            end
        end

        case (state_reg)
            SET_IDLE: ;
            SET_POS: begin
                if (mul_done) begin
                    pos_next[k_reg] = mul_sum[OFFSET_BITS-1:0];
                    if (k_reg == LAST_IDX) begin
                        state_next = SET_STRIDE;
                    end
                    else begin
                        k_next = k_reg + IDX_W'(1);
                    end
                end
            end
            SET_STRIDE: begin
                // First output position naming a dimension gives its stride
                for (int d = 0; d < MAX_DIMS; d++) begin
                    stride_next[d] = '0;
                    hit = 1'b0;
                    for (int k = 0; k < MAX_DIMS; k++) begin
                        if (!hit && d < int'(dims) && k < int'(dims) &&
                            int'(pe[k]) == d) begin
                            hit            = 1'b1;
                            stride_next[d] = pos_reg[k];
                        end
                    end
                end
                rew_acc_next = '0;
                k_next       = '0;
                step_next    = '0;
                state_next   = SET_REW;
            end
            SET_REW: begin
                if (mul_done) begin
                    // Step into dimension k after all lower ones rewind from their maxima
                    delta_next[k_reg] = stride_reg[k_reg] - rew_acc_reg;
                    rew_acc_next      = rew_acc_reg + mul_sum[OFFSET_BITS-1:0];
                    if (k_reg == LAST_IDX) begin
                        k_next     = '0;
                        cnt_next   = MUL_W'(1);
                        state_next = SET_CNT;
                    end
                    else begin
                        k_next = k_reg + IDX_W'(1);
                    end
                end
            end
            SET_CNT: begin
                if (mul_done) begin
                    cnt_next = mul_sum;
                    if (int'(k_reg) + 1 == int'(dims)) begin
                        state_next = SET_FIN;
                    end
                    else begin
                        k_next = k_reg + IDX_W'(1);
                    end
                end
            end
            SET_FIN: begin
                ovf_next   = cnt_reg > OFFSET_SPAN;
                state_next = SET_IDLE;
            end
            default: state_next = SET_IDLE;
        endcase

        // Any write restarts the whole derivation
        if (cfg_we) begin
            state_next  = SET_POS;
            k_next      = IDX_W'(1);
            step_next   = '0;
            pos_next[0] = OFFSET_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= SET_IDLE;
            k_reg     <= '0;
            step_reg  <= '0;
            ovf_reg   <= 1'b0;
            for (int d = 0; d < MAX_DIMS; d++) begin
                delta_reg[d] <= (d == 0) ? OFFSET_BITS'(1) : '0;
            end
        end
        else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            step_reg  <= step_next;
            ovf_reg   <= ovf_next;
            delta_reg <= delta_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        prod_reg    <= prod_next;
        pos_reg     <= pos_next;
        stride_reg  <= stride_next;
        rew_acc_reg <= rew_acc_next;
        cnt_reg     <= cnt_next;
    end

    assign carry_step         = delta_reg;
    assign stat.busy          = (state_reg != SET_IDLE) || cfg_we;
    assign stat.restart       = cfg_we;
    assign stat.size_overflow = ovf_reg;

endmodule

// ===== sv/tts_front.sv =====
// Front end: takes element beats and tags each with its destination offset
// from the mixed-radix coordinate counter. Depends on tts_pkg and tts_if.
module tts_front
    import tts_pkg::*;
#(
    parameter int MAX_DIMS    = 6,
    parameter int OFFSET_BITS = 48
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    tts_elem_if.sink               elem,
    input  logic [DIM_W-1:0]       dims,
    input  logic [COORD_W-1:0]     coord_max [MAX_DIMS],
    input  logic [OFFSET_BITS-1:0] carry_step [MAX_DIMS],
    input  setup_stat_t            stat,
    input  logic                   queue_full,
    output logic                   push,
    output result_t                push_data
);

    logic [COORD_W-1:0]            coord_reg [MAX_DIMS];
    logic [COORD_W-1:0]            coord_next [MAX_DIMS];
    logic [COORD_W-1:0]            coord_step [MAX_DIMS];
    logic [OFFSET_BITS-1:0]        offset_reg, offset_next, offset_step, step_add;
    logic [OFFSET_BITS+DEST_W-1:0] offset_wide;
    logic [MAX_DIMS-1:0]           in_use, at_max;
    logic                          hit, last;

    assign elem.ready = !stat.busy && !queue_full;
    assign push       = elem.valid && elem.ready;

    always_comb
    begin
        last     = 1'b1;
        hit      = 1'b0;
        step_add = '0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            in_use[d] = d < int'(dims);
            at_max[d] = coord_reg[d] == coord_max[d];
            if (in_use[d] && !at_max[d]) begin
                last = 1'b0;
            end
        end
        // Advance the lowest dimension not at its maximum, clear those below
        for (int d = 0; d < MAX_DIMS; d++) begin
            coord_step[d] = coord_reg[d];
            if (!hit) begin
                if (in_use[d] && !at_max[d]) begin
                    hit           = 1'b1;
                    coord_step[d] = coord_reg[d] + COORD_W'(1);
                    step_add      = carry_step[d];
                end
                else begin
                    coord_step[d] = '0;
                end
            end
        end
        offset_step = hit ? offset_reg + step_add : '0;

        coord_next  = coord_reg;
        offset_next = offset_reg;
        if (stat.restart) begin
            for (int d = 0; d < MAX_DIMS; d++) begin
                coord_next[d] = '0;
            end
            offset_next = '0;
        end
        else if (push) begin
            coord_next  = coord_step;
            offset_next = offset_step;
        end

        offset_wide             = {{DEST_W{1'b0}}, offset_reg};
        push_data.dest_offset   = offset_wide[DEST_W-1:0];
        push_data.value_out     = elem.element_value;
        push_data.last_element  = last;
        push_data.size_overflow = stat.size_overflow;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int d = 0; d < MAX_DIMS; d++) begin
                coord_reg[d] <= '0;
            end
            offset_reg <= '0;
        end
        else begin
            coord_reg  <= coord_next;
            offset_reg <= offset_next;
        end
    end

endmodule

// ===== sv/tts_back.sv =====
// Back end: two-entry result queue that drives the result channel from
// registers. Depends on tts_pkg and tts_if.
module tts_back
    import tts_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  result_t       push_data,
    output logic          full,
    tts_result_if.source  result
);

    result_t             slot_reg [QUEUE_DEPTH];
    result_t             head;
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                pop;

    assign pop  = result.valid && result.ready;
    assign full = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign head = slot_reg[rd_ptr_reg];

    assign result.valid         = count_reg != '0;
    assign result.dest_offset   = head.dest_offset;
    assign result.value_out     = head.value_out;
    assign result.last_element  = head.last_element;
    assign result.size_overflow = head.size_overflow;

    assign count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/tensor_transpose_scatter.sv =====
// Tensor transpose scatter: tags each source element with its offset in the permuted tensor.
// An accepted beat is registered into the result queue and is offered once it reaches the head.
// Throughput: one element per cycle while no setup pass runs and the two-entry result queue is not full.
// A register write starts a setup pass on one shift-add multiplier over the 13 multiplier bits,
// forming position, rewind and element-count products in turn, with element intake held off meanwhile.
// Reset: one dimension of size one, identity permutation, counter at zero; no setup pass needed.
module tensor_transpose_scatter
    import tts_pkg::*;
#(
    parameter int MAX_DIMS    = 6,
    parameter int OFFSET_BITS = 48
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    tts_elem_if.sink              elem,
    tts_result_if.source          result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [DIM_W-1:0]       dims;
    logic [COORD_W-1:0]     coord_max [MAX_DIMS];
    logic [OFFSET_BITS-1:0] carry_step [MAX_DIMS];
    setup_stat_t            stat;
    logic                   queue_full;
    logic                   push;
    result_t                push_data;

    tts_cfg #(
        .MAX_DIMS    (MAX_DIMS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .dims       (dims),
        .coord_max  (coord_max),
        .carry_step (carry_step),
        .stat       (stat)
    );

    tts_front #(
        .MAX_DIMS    (MAX_DIMS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .elem       (elem),
        .dims       (dims),
        .coord_max  (coord_max),
        .carry_step (carry_step),
        .stat       (stat),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    tts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .result    (result)
    );

    // Hold intake for the setup pass that a write starts
    a_cfg_blocks_intake: assert property (
        @(posedge clk) disable iff (!rst_n)
        cfg_we |=> !elem.ready
    ) else $error("element intake open right after a register write");

    // Setup only ever starts from a register write
    a_busy_from_write: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(stat.busy) |-> cfg_we
    ) else $error("setup started without a register write");

    // Every accepted element beat shows up in the result queue
    a_accept_reaches_queue: assert property (
        @(posedge clk) disable iff (!rst_n)
        (elem.valid && elem.ready) |=> result.valid
    ) else $error("accepted element beat missing from result channel");

endmodule
